### sv/charger_presence_supervisor_top_defines.svh
// Assertion macros used by the supervisor top-level RTL.
`ifndef CHARGER_PRESENCE_SUPERVISOR_TOP_DEFINES_SVH
`define CHARGER_PRESENCE_SUPERVISOR_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define CPS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define CPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cps_pkg.sv
package cps_pkg;

  localparam int ELAPSED_BITS = 8;
  localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = {ELAPSED_BITS{1'b1}};
  localparam int CMP_W = (ELAPSED_BITS > 8) ? ELAPSED_BITS : 8;

  localparam int MV_W = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 14;

  typedef enum logic [1:0] {
    SRC_LINE = 2'd0,
    SRC_USB  = 2'd1,
    SRC_BAT  = 2'd2
  } src_t;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PRE  = 2'd1;
  localparam logic [1:0] ST_FAST = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [2:0] NTC_COLD = 3'd1;
  localparam logic [2:0] NTC_HOT  = 3'd2;

  localparam logic [1:0] CFLT_INPUT   = 2'd1;
  localparam logic [1:0] CFLT_THERMAL = 2'd2;
  localparam logic [1:0] CFLT_TIMER   = 2'd3;

  localparam logic [2:0] FLT_NONE    = 3'd0;
  localparam logic [2:0] FLT_OVP     = 3'd1;
  localparam logic [2:0] FLT_TIMER   = 3'd2;
  localparam logic [2:0] FLT_COLD    = 3'd3;
  localparam logic [2:0] FLT_HOT     = 3'd4;
  localparam logic [2:0] FLT_INPUT   = 3'd5;
  localparam logic [2:0] FLT_THERMAL = 3'd6;
  localparam logic [2:0] FLT_NO_BAT  = 3'd7;

  localparam logic [3:0] SHORT_MAX = 4'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_TH    = 3'd0,
    REG_USB_TH     = 3'd1,
    REG_OTG_WARN   = 3'd2,
    REG_PRESENT_TH = 3'd3,
    REG_SHORT_TK   = 3'd4,
    REG_SHORT_LIM  = 3'd5,
    REG_RECHECK    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [MV_W-1:0] line_threshold_mv;
    logic [MV_W-1:0] usb_threshold_mv;
    logic [MV_W-1:0] otg_vbus_warn_mv;
    logic [MV_W-1:0] present_threshold_mv;
    logic [7:0]      short_charge_ticks;
    logic [3:0]      short_cycle_limit;
    logic [3:0]      recheck_period;
  } cps_cfg_t;

  typedef struct packed {
    logic            vbus_is_otg;
    logic [1:0]      charge_status;
    logic [MV_W-1:0] vbus_mv;
    logic [MV_W-1:0] vbat_mv;
    logic            bat_overvoltage;
    logic            watchdog_expired;
    logic [2:0]      thermistor_code;
    logic [1:0]      charge_fault;
  } cps_in_t;

  typedef struct packed {
    logic [1:0] power_source;
    logic       battery_present;
    logic       enable_write;
    logic       charge_enable;
    logic       load_enable;
    logic       otg_load_off;
    logic       vbus_inconsistent;
    logic       is_charging;
    logic [2:0] fault_code;
  } cps_out_t;

endpackage

### sv/charger_presence_supervisor_top.sv
// Charger presence supervisor.
// Feed one input word per status tick on in_valid / in_stall: the charger's
// OTG flag, charge status, VBUS and VBAT readings and fault bits. Each word
// yields exactly one result word on out_valid / out_stall: power source,
// battery presence, enable write and values, OTG load-off, VBUS
// inconsistency, charging flag and the prioritized fault code.
// Path: an accepted word lands in the input register and, once the result
// register is free or being taken, its result is registered there and
// out_valid rises. Throughput is one word per cycle while out_stall is low;
// the single pass from input register through the compare/count logic to
// the result register sets that figure.
// Stall: a held result blocks the output register; one more word is still
// taken into the input register, and in_stall rises only once that is full.
// Reset (rst_n low, synchronous): thresholds return to their defaults,
// supervisor state clears with the battery assumed present, both registers
// empty. cfg_we writes register cfg_index; write only while idle.
`include "charger_presence_supervisor_top_defines.svh"

module charger_presence_supervisor_top
  import cps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cps_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cps_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cps_cfg_t cfg;
  cps_in_t  in_data_r;
  logic     in_valid_r;
  cps_out_t result;
  cps_out_t out_data_r;
  logic     out_valid_r;
  logic     adv;
  logic     in_take;

  cps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // a word moves on when the result register is empty or being drained
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  cps_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (in_data_r),
    .cfg    (cfg),
    .result (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CPS_ASSERT(a_absent_fault, out_valid_r && !out_data_r.battery_present, out_data_r.fault_code == FLT_NO_BAT, "absent battery without no-battery fault")
  `CPS_ASSERT(a_loadoff_src, out_valid_r && out_data_r.otg_load_off, out_data_r.power_source == SRC_BAT && !out_data_r.enable_write && !out_data_r.load_enable || out_data_r.enable_write, "OTG load-off outside battery source")
  `CPS_ASSERT(a_incons_src, out_valid_r && out_data_r.vbus_inconsistent, out_data_r.power_source == SRC_BAT, "VBUS inconsistency outside OTG")
  `CPS_ASSERT_NEXT(a_adv_out, adv, out_valid_r, "advanced word did not reach result register")

endmodule

### sv/cps_cfg_regs.sv
module cps_cfg_regs
  import cps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cps_cfg_t              cfg
);

  cps_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_threshold_mv    <= 14'd4900;
      cfg_r.usb_threshold_mv     <= 14'd4200;
      cfg_r.otg_vbus_warn_mv     <= 14'd3500;
      cfg_r.present_threshold_mv <= 14'd3000;
      cfg_r.short_charge_ticks   <= 8'd15;
      cfg_r.short_cycle_limit    <= 4'd3;
      cfg_r.recheck_period       <= 4'd4;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LINE_TH:    cfg_r.line_threshold_mv    <= cfg_wdata;
        REG_USB_TH:     cfg_r.usb_threshold_mv     <= cfg_wdata;
        REG_OTG_WARN:   cfg_r.otg_vbus_warn_mv     <= cfg_wdata;
        REG_PRESENT_TH: cfg_r.present_threshold_mv <= cfg_wdata;
        REG_SHORT_TK:   cfg_r.short_charge_ticks   <= cfg_wdata[7:0];
        REG_SHORT_LIM:  cfg_r.short_cycle_limit    <= cfg_wdata[3:0];
        REG_RECHECK:    cfg_r.recheck_period       <= cfg_wdata[3:0];
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/cps_core.sv
module cps_core
  import cps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  cps_in_t  item,
  input  cps_cfg_t cfg,
  output cps_out_t result
);

  logic [1:0]              source_r, source_nxt;
  logic                    otg_seen_r, otg_seen_nxt;
  logic [1:0]              prev_status_r, prev_status_nxt;
  logic [ELAPSED_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [3:0]              short_r, short_nxt;
  logic                    present_r, present_nxt;
  logic [3:0]              recheck_r, recheck_nxt;
  logic                    chg_en_r, chg_en_nxt;
  logic                    load_en_r, load_en_nxt;

  logic       wrote, load_off, incons;
  logic [2:0] fault;
  logic [4:0] rc_plus;

  always_comb begin
    source_nxt      = source_r;
    otg_seen_nxt    = otg_seen_r;
    prev_status_nxt = prev_status_r;
    short_nxt       = short_r;
    present_nxt     = present_r;
    chg_en_nxt      = chg_en_r;
    load_en_nxt     = load_en_r;
    wrote           = 1'b0;
    load_off        = 1'b0;
    incons          = 1'b0;
    fault           = FLT_NONE;
    rc_plus         = {1'b0, recheck_r} + 5'd1;

    // tick ages the current cycle first
    elapsed_nxt = (elapsed_r < ELAPSED_MAX) ? elapsed_r + 1'b1 : elapsed_r;

    // source classification; low VBUS keeps the last source
    if (item.vbus_is_otg) begin
      if (!otg_seen_r) begin
        otg_seen_nxt = 1'b1;
        load_off     = 1'b1;
        load_en_nxt  = 1'b0;
      end
      source_nxt = SRC_BAT;
      incons     = item.vbus_mv > cfg.otg_vbus_warn_mv;
    end else begin
      otg_seen_nxt = 1'b0;
      if (item.vbus_mv > cfg.line_threshold_mv) begin
        source_nxt = SRC_LINE;
      end else if (item.vbus_mv > cfg.usb_threshold_mv) begin
        source_nxt = SRC_USB;
      end
    end

    // charge-cycle tracking, only while externally powered
    if (source_nxt != SRC_BAT) begin
      if (item.charge_status != prev_status_r) begin
        prev_status_nxt = item.charge_status;
        case (item.charge_status)
          ST_DONE: begin
            if (CMP_W'(elapsed_nxt) < CMP_W'(cfg.short_charge_ticks)) begin
              if (short_r >= cfg.short_cycle_limit) begin
                present_nxt = 1'b0;
                load_en_nxt = 1'b1;
                chg_en_nxt  = 1'b0;
                wrote       = 1'b1;
              end
              if (short_r < SHORT_MAX) begin
                short_nxt = short_r + 4'd1;
              end
            end
          end
          ST_FAST: elapsed_nxt = '0;
          ST_PRE: begin
            elapsed_nxt = '0;
            short_nxt   = 4'd0;
          end
          default: short_nxt = 4'd0;
        endcase
      end
    end else begin
      present_nxt = 1'b1;
    end

    // periodic presence recheck; its enables win over an absence write
    if (rc_plus >= {1'b0, cfg.recheck_period}) begin
      recheck_nxt = 4'd0;
      if (!present_nxt) begin
        elapsed_nxt = '0;
        load_en_nxt = 1'b1;
        if (item.vbat_mv > cfg.present_threshold_mv) begin
          chg_en_nxt  = 1'b1;
          present_nxt = 1'b1;
        end else begin
          chg_en_nxt = 1'b0;
        end
      end else begin
        chg_en_nxt  = 1'b1;
        load_en_nxt = 1'b0;
      end
      wrote = 1'b1;
    end else begin
      recheck_nxt = rc_plus[3:0];
    end

    if (item.bat_overvoltage)                   fault = FLT_OVP;
    else if (item.watchdog_expired)             fault = FLT_TIMER;
    else if (item.thermistor_code == NTC_COLD)  fault = FLT_COLD;
    else if (item.thermistor_code == NTC_HOT)   fault = FLT_HOT;
    else if (item.charge_fault == CFLT_INPUT)   fault = FLT_INPUT;
    else if (item.charge_fault == CFLT_THERMAL) fault = FLT_THERMAL;
    else if (item.charge_fault == CFLT_TIMER)   fault = FLT_TIMER;
    if (!present_nxt) fault = FLT_NO_BAT;

    result.power_source      = source_nxt;
    result.battery_present   = present_nxt;
    result.enable_write      = wrote;
    result.charge_enable     = chg_en_nxt;
    result.load_enable       = load_en_nxt;
    result.otg_load_off      = load_off;
    result.vbus_inconsistent = incons;
    result.is_charging       = (item.charge_status == ST_PRE) ||
                               (item.charge_status == ST_FAST);
    result.fault_code        = fault;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_r      <= SRC_LINE;
      otg_seen_r    <= 1'b0;
      prev_status_r <= ST_IDLE;
      elapsed_r     <= '0;
      short_r       <= 4'd0;
      present_r     <= 1'b1;
      recheck_r     <= 4'd0;
      chg_en_r      <= 1'b0;
      load_en_r     <= 1'b0;
    end else if (adv) begin
      source_r      <= source_nxt;
      otg_seen_r    <= otg_seen_nxt;
      prev_status_r <= prev_status_nxt;
      elapsed_r     <= elapsed_nxt;
      short_r       <= short_nxt;
      present_r     <= present_nxt;
      recheck_r     <= recheck_nxt;
      chg_en_r      <= chg_en_nxt;
      load_en_r     <= load_en_nxt;
    end
  end

endmodule

### sim/charger_presence_supervisor_top_tb.sv
`timescale 1ns / 1ps

module charger_presence_supervisor_top_tb;
  import cps_pkg::*;

  // Cycles with no word moving on either channel before the run is abandoned.
  localparam int STALL_LIMIT = 4000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  cps_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  cps_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  charger_presence_supervisor_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Ticks waiting to be sent, and the status words they must produce, oldest first.
  cps_in_t  tick_backlog[$];
  cps_out_t expected_status[$];

  int  mismatches = 0;
  int  quiet_cycles = 0;
  // When set, neither side idles: back-to-back words for a whole phase.
  bit  calm = 1'b0;

  // ---------------------------------------------------------------------------
  // Supervisor shadow: thresholds plus the tick-to-tick state.
  // ---------------------------------------------------------------------------
  cps_cfg_t                sup_cfg;
  src_t                    src_q;
  logic                    otg_latched;
  logic [1:0]              prev_stat;
  logic [ELAPSED_BITS-1:0] cycle_ticks;
  logic [3:0]              short_cnt;
  logic                    bat_present;
  logic [3:0]              recheck_cnt;
  logic                    chg_en;
  logic                    load_en;

  task automatic reset_shadow();
    sup_cfg.line_threshold_mv    = 14'd4900;
    sup_cfg.usb_threshold_mv     = 14'd4200;
    sup_cfg.otg_vbus_warn_mv     = 14'd3500;
    sup_cfg.present_threshold_mv = 14'd3000;
    sup_cfg.short_charge_ticks   = 8'd15;
    sup_cfg.short_cycle_limit    = 4'd3;
    sup_cfg.recheck_period       = 4'd4;
    src_q       = SRC_LINE;
    otg_latched = 1'b0;
    prev_stat   = ST_IDLE;
    cycle_ticks = '0;
    short_cnt   = '0;
    bat_present = 1'b1;
    recheck_cnt = '0;
    chg_en      = 1'b0;
    load_en     = 1'b0;
  endtask

  // One tick through the supervisor: updates the shadow, returns the status word.
  function automatic cps_out_t supervise_tick(cps_in_t w);
    cps_out_t   r;
    logic       wrote;
    logic       load_off;
    logic       incons;
    logic [2:0] flt;
    logic [4:0] next_cnt;
    r        = '0;
    wrote    = 1'b0;
    load_off = 1'b0;
    incons   = 1'b0;
    flt      = FLT_NONE;

    if (cycle_ticks != ELAPSED_MAX) cycle_ticks = cycle_ticks + 1'b1;

    // Source: OTG forces battery; otherwise VBUS picks line or USB, and a
    // low VBUS leaves the previous source in place.
    if (w.vbus_is_otg) begin
      if (!otg_latched) begin
        otg_latched = 1'b1;
        load_off    = 1'b1;
        load_en     = 1'b0;
      end
      src_q  = SRC_BAT;
      incons = (w.vbus_mv > sup_cfg.otg_vbus_warn_mv);
    end else begin
      otg_latched = 1'b0;
      if (w.vbus_mv > sup_cfg.line_threshold_mv) src_q = SRC_LINE;
      else if (w.vbus_mv > sup_cfg.usb_threshold_mv) src_q = SRC_USB;
    end

    // Charge-cycle tracking only while externally powered.
    if (src_q != SRC_BAT) begin
      if (w.charge_status != prev_stat) begin
        prev_stat = w.charge_status;
        case (w.charge_status)
          ST_DONE: begin
            if (cycle_ticks < sup_cfg.short_charge_ticks) begin
              if (short_cnt >= sup_cfg.short_cycle_limit) begin
                bat_present = 1'b0;
                load_en     = 1'b1;
                chg_en      = 1'b0;
                wrote       = 1'b1;
              end
              if (short_cnt != SHORT_MAX) short_cnt = short_cnt + 1'b1;
            end
          end
          ST_FAST: cycle_ticks = '0;
          ST_PRE: begin
            cycle_ticks = '0;
            short_cnt   = '0;
          end
          default: short_cnt = '0;
        endcase
      end
    end else begin
      bat_present = 1'b1;
    end

    // Periodic recheck; a period of zero behaves as one.
    next_cnt = {1'b0, recheck_cnt} + 5'd1;
    if (next_cnt >= {1'b0, sup_cfg.recheck_period}) begin
      recheck_cnt = '0;
      if (!bat_present) begin
        cycle_ticks = '0;
        load_en     = 1'b1;
        if (w.vbat_mv > sup_cfg.present_threshold_mv) begin
          chg_en      = 1'b1;
          bat_present = 1'b1;
        end else begin
          chg_en = 1'b0;
        end
      end else begin
        chg_en  = 1'b1;
        load_en = 1'b0;
      end
      wrote = 1'b1;
    end else begin
      recheck_cnt = next_cnt[3:0];
    end

    if (w.bat_overvoltage) flt = FLT_OVP;
    else if (w.watchdog_expired) flt = FLT_TIMER;
    else if (w.thermistor_code == NTC_COLD) flt = FLT_COLD;
    else if (w.thermistor_code == NTC_HOT) flt = FLT_HOT;
    else if (w.charge_fault == CFLT_INPUT) flt = FLT_INPUT;
    else if (w.charge_fault == CFLT_THERMAL) flt = FLT_THERMAL;
    else if (w.charge_fault == CFLT_TIMER) flt = FLT_TIMER;
    if (!bat_present) flt = FLT_NO_BAT;

    r.power_source      = src_q;
    r.battery_present   = bat_present;
    r.enable_write      = wrote;
    r.charge_enable     = chg_en;
    r.load_enable       = load_en;
    r.otg_load_off      = load_off;
    r.vbus_inconsistent = incons;
    r.is_charging       = (w.charge_status == ST_PRE) || (w.charge_status == ST_FAST);
    r.fault_code        = flt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------------
  function automatic logic [MV_W-1:0] clamp_mv(int v);
    if (v < 0) return '0;
    if (v > 16383) return 14'd16383;
    return v[MV_W-1:0];
  endfunction

  function automatic cps_in_t mk_word(logic otg, logic [1:0] stat, int vbus, int vbat,
                                      logic ovp, logic wdog, logic [2:0] ntc,
                                      logic [1:0] cflt);
    cps_in_t w;
    w.vbus_is_otg      = otg;
    w.charge_status    = stat;
    w.vbus_mv          = clamp_mv(vbus);
    w.vbat_mv          = clamp_mv(vbat);
    w.bat_overvoltage  = ovp;
    w.watchdog_expired = wdog;
    w.thermistor_code  = ntc;
    w.charge_fault     = cflt;
    return w;
  endfunction

  // VBUS mostly above the USB threshold so charge tracking stays live,
  // with a share hugging each threshold.
  function automatic int pick_vbus();
    int usb;
    usb = int'(sup_cfg.usb_threshold_mv);
    case ($urandom_range(0, 7))
      0: return int'(sup_cfg.line_threshold_mv) + $urandom_range(0, 4) - 2;
      1: return usb + $urandom_range(0, 4) - 2;
      2: return int'(sup_cfg.otg_vbus_warn_mv) + $urandom_range(0, 4) - 2;
      3: return $urandom_range(0, 16383);
      default: return (usb >= 16383) ? 16383 : $urandom_range(usb + 1, 16383);
    endcase
  endfunction

  function automatic int pick_vbat();
    if ($urandom_range(0, 1) == 0)
      return int'(sup_cfg.present_threshold_mv) + $urandom_range(0, 6) - 3;
    return $urandom_range(0, 16383);
  endfunction

  // Plausible tick; faults show up on about one tick in five.
  function automatic cps_in_t run_word(logic otg, logic [1:0] stat);
    logic [31:0] raw;
    logic        faulty;
    raw    = $urandom;
    faulty = ($urandom_range(0, 4) == 0);
    return mk_word(otg, stat, pick_vbus(), pick_vbat(), faulty & raw[0], faulty & raw[1],
                   faulty ? raw[4:2] : 3'd0, faulty ? raw[6:5] : 2'd0);
  endfunction

  function automatic cps_in_t noise_word();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(cps_in_t)-1:0];
  endfunction

  // A run of fast-charge / done cycles, mostly short enough to count, then a
  // tail of done ticks so rechecks land while the battery may be absent.
  function automatic void push_charge_run();
    int         cycles;
    int         dur;
    int         sct;
    logic [1:0] cyc_stat;
    sct    = int'(sup_cfg.short_charge_ticks);
    cycles = $urandom_range(1, int'(sup_cfg.short_cycle_limit) + 3);
    if ($urandom_range(0, 2) == 0)
      tick_backlog.push_back(run_word(1'b0, ($urandom_range(0, 1) != 0) ? ST_PRE : ST_IDLE));
    repeat (cycles) begin
      cyc_stat = ($urandom_range(0, 15) == 0) ? ST_PRE : ST_FAST;
      if ($urandom_range(0, 5) == 0) dur = sct + $urandom_range(0, 8);
      else dur = $urandom_range(1, (sct > 12) ? 12 : ((sct > 1) ? sct : 1));
      repeat (dur) tick_backlog.push_back(run_word(1'b0, cyc_stat));
      repeat ($urandom_range(1, 3)) tick_backlog.push_back(run_word(1'b0, ST_DONE));
      if ($urandom_range(0, 11) == 0)
        repeat ($urandom_range(1, 3)) tick_backlog.push_back(run_word(1'b1, ST_DONE));
    end
    repeat ($urandom_range(1, 18)) tick_backlog.push_back(run_word(1'b0, ST_DONE));
  endfunction

  function automatic void queue_random(int n);
    int goal;
    goal = tick_backlog.size() + n;
    while (tick_backlog.size() < goal) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 8)) tick_backlog.push_back(noise_word());
      else
        push_charge_run();
    end
  endfunction

  // Threshold edges, every status and fault priority, OTG entry, then four
  // short cycles to declare the battery absent and rechecks to bring it back.
  function automatic void queue_directed();
    tick_backlog.push_back(mk_word(1'b0, ST_IDLE, 0, 0, 1'b0, 1'b0, 3'd0, 2'd0));
    tick_backlog.push_back(mk_word(1'b0, ST_FAST, 16383, 16383, 1'b1, 1'b1, NTC_COLD,
                                   CFLT_INPUT));
    tick_backlog.push_back(mk_word(1'b0, ST_FAST, 4900, 3000, 1'b0, 1'b1, NTC_HOT,
                                   CFLT_TIMER));
    tick_backlog.push_back(mk_word(1'b0, ST_FAST, 4901, 3001, 1'b0, 1'b0, NTC_COLD,
                                   CFLT_THERMAL));
    tick_backlog.push_back(mk_word(1'b0, ST_FAST, 4200, 2999, 1'b0, 1'b0, NTC_HOT,
                                   CFLT_INPUT));
    tick_backlog.push_back(mk_word(1'b0, ST_FAST, 4201, 1000, 1'b0, 1'b0, 3'd3, CFLT_INPUT));
    tick_backlog.push_back(mk_word(1'b0, ST_PRE, 6000, 1000, 1'b0, 1'b0, 3'd0, CFLT_THERMAL));
    tick_backlog.push_back(mk_word(1'b0, ST_DONE, 6000, 1000, 1'b0, 1'b0, 3'd4, CFLT_TIMER));
    tick_backlog.push_back(mk_word(1'b0, ST_IDLE, 6000, 1000, 1'b0, 1'b0, 3'd7, 2'd0));
    tick_backlog.push_back(mk_word(1'b1, ST_FAST, 3501, 1000, 1'b0, 1'b0, 3'd0, 2'd0));
    tick_backlog.push_back(mk_word(1'b1, ST_DONE, 3500, 1000, 1'b0, 1'b0, 3'd0, 2'd0));
    tick_backlog.push_back(mk_word(1'b0, ST_PRE, 100, 1000, 1'b0, 1'b0, 3'd0, 2'd0));
    tick_backlog.push_back(mk_word(1'b0, ST_IDLE, 16383, 1000, 1'b0, 1'b0, 3'd0, 2'd0));
    repeat (4) begin
      tick_backlog.push_back(mk_word(1'b0, ST_FAST, 16383, 4000, 1'b0, 1'b0, 3'd0, 2'd0));
      tick_backlog.push_back(mk_word(1'b0, ST_DONE, 16383, 4000, 1'b0, 1'b0, 3'd0, 2'd0));
    end
    repeat (3)
      tick_backlog.push_back(mk_word(1'b0, ST_DONE, 16383, 2000, 1'b0, 1'b0, 3'd0, 2'd0));
    tick_backlog.push_back(mk_word(1'b0, ST_DONE, 16383, 3001, 1'b0, 1'b0, 3'd0, 2'd0));
  endfunction

  // ---------------------------------------------------------------------------
  // Register writes: only issued once the block has gone quiet.
  // ---------------------------------------------------------------------------
  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_LINE_TH:    sup_cfg.line_threshold_mv    = val[MV_W-1:0];
      REG_USB_TH:     sup_cfg.usb_threshold_mv     = val[MV_W-1:0];
      REG_OTG_WARN:   sup_cfg.otg_vbus_warn_mv     = val[MV_W-1:0];
      REG_PRESENT_TH: sup_cfg.present_threshold_mv = val[MV_W-1:0];
      REG_SHORT_TK:   sup_cfg.short_charge_ticks   = val[7:0];
      REG_SHORT_LIM:  sup_cfg.short_cycle_limit    = val[3:0];
      REG_RECHECK:    sup_cfg.recheck_period       = val[3:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(int unsigned line_mv, int unsigned usb_mv, int unsigned warn_mv,
                               int unsigned pres_mv, int unsigned ticks, int unsigned lim,
                               int unsigned period);
    write_reg(REG_LINE_TH, line_mv);
    write_reg(REG_USB_TH, usb_mv);
    write_reg(REG_OTG_WARN, warn_mv);
    write_reg(REG_PRESENT_TH, pres_mv);
    write_reg(REG_SHORT_TK, ticks);
    write_reg(REG_SHORT_LIM, lim);
    write_reg(REG_RECHECK, period);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender holds off until every queued tick went in and every status word
  // came back. Sampled on the falling edge, clear of the handshake edge.
  task automatic drain();
    do @(negedge clk);
    while (in_valid || tick_backlog.size() != 0 || expected_status.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: predict on every accepted word, then present the next one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_status.push_back(supervise_tick(in_data));
      // A stalled word stays put; otherwise load the next one or idle.
      if (!in_valid || !in_stall) begin
        if (tick_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
          in_valid <= 1'b1;
          in_data  <= tick_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, field-by-field compare against the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    cps_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        $error("status word with no tick outstanding: %h", out_data);
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        compare_field("power_source", want.power_source, out_data.power_source);
        compare_field("battery_present", want.battery_present, out_data.battery_present);
        compare_field("enable_write", want.enable_write, out_data.enable_write);
        compare_field("charge_enable", want.charge_enable, out_data.charge_enable);
        compare_field("load_enable", want.load_enable, out_data.load_enable);
        compare_field("otg_load_off", want.otg_load_off, out_data.otg_load_off);
        compare_field("vbus_inconsistent", want.vbus_inconsistent, out_data.vbus_inconsistent);
        compare_field("is_charging", want.is_charging, out_data.is_charging);
        compare_field("fault_code", want.fault_code, out_data.fault_code);
      end
    end
    out_stall <= !calm && ($urandom_range(0, 99) < 18);
  end

  // Watchdog: any word moving on either channel resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("charger_presence_supervisor_top_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Phases: each one programs the thresholds on an idle block, then streams.
  // ---------------------------------------------------------------------------
  initial begin
    reset_shadow();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Power-on thresholds.
    queue_directed();
    drain();
    queue_random(260);
    drain();

    // Upper extremes; USB/warn at zero so any nonzero VBUS counts.
    load_settings(16383, 0, 0, 16383, 255, 15, 15);
    queue_random(260);
    drain();

    // All zero: no cycle is short, recheck on every tick.
    load_settings(0, 0, 0, 0, 0, 0, 0);
    queue_random(230);
    drain();

    // First short cycle declares absence; back-to-back words both sides.
    load_settings(5000, 4000, 3000, 3300, 20, 0, 1);
    calm = 1'b1;
    queue_random(260);
    drain();
    calm = 1'b0;

    repeat (3) begin
      load_settings($urandom_range(0, 16383), $urandom_range(0, 16383),
                    $urandom_range(0, 16383), $urandom_range(0, 16383),
                    $urandom_range(1, 40), $urandom_range(0, 6), $urandom_range(0, 15));
      queue_random(210);
      drain();
    end

    // Spare cycles catch any stray status word.
    repeat (6) @(posedge clk);
    if (expected_status.size() != 0) begin
      $error("%0d status words never arrived", expected_status.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("charger_presence_supervisor_top_tb passed");
    end else begin
      $display("charger_presence_supervisor_top_tb failed");
    end
    $finish;
  end

endmodule
